@@ sv/rvx_pkg.sv @@
package rvx_pkg;

  localparam int XLEN        = 32;
  localparam int REG_COUNT   = 32;
  localparam int REG_AW      = $clog2(REG_COUNT);
  localparam int UPPER_SHIFT = 12;
  localparam int INSTR_BYTES = 4;

  // Operation codes of the pre-decoded instruction
  typedef enum logic [5:0] {
    OP_UNIMPL = 6'd0,
    OP_ADD    = 6'd1,
    OP_AND    = 6'd2,
    OP_OR     = 6'd3,
    OP_XOR    = 6'd4,
    OP_SUB    = 6'd5,
    OP_SLL    = 6'd6,
    OP_SRL    = 6'd7,
    OP_SRA    = 6'd8,
    OP_SLT    = 6'd9,
    OP_SLTU   = 6'd10,
    OP_ADDI   = 6'd11,
    OP_ANDI   = 6'd12,
    OP_ORI    = 6'd13,
    OP_XORI   = 6'd14,
    OP_SLLI   = 6'd15,
    OP_SRLI   = 6'd16,
    OP_SRAI   = 6'd17,
    OP_SLTI   = 6'd18,
    OP_SLTIU  = 6'd19,
    OP_LB     = 6'd20,
    OP_LBU    = 6'd21,
    OP_LH     = 6'd22,
    OP_LHU    = 6'd23,
    OP_LW     = 6'd24,
    OP_SB     = 6'd25,
    OP_SH     = 6'd26,
    OP_SW     = 6'd27,
    OP_BEQ    = 6'd28,
    OP_BNE    = 6'd29,
    OP_BGE    = 6'd30,
    OP_BGEU   = 6'd31,
    OP_BLT    = 6'd32,
    OP_BLTU   = 6'd33,
    OP_JAL    = 6'd34,
    OP_JALR   = 6'd35,
    OP_AUIPC  = 6'd36,
    OP_LUI    = 6'd37,
    OP_HCF    = 6'd38
  } op_e;

  // Memory access widths
  localparam logic [1:0] MEM_BYTE = 2'd0;
  localparam logic [1:0] MEM_HALF = 2'd1;
  localparam logic [1:0] MEM_WORD = 2'd2;

  // Action codes
  localparam logic ACT_EXEC = 1'b0;
  localparam logic ACT_LRET = 1'b1;

  // What one executed instruction does
  typedef struct packed {
    logic            wr_en;
    logic [XLEN-1:0] wr_data;
    logic [XLEN-1:0] next_pc;
    logic            taken;
    logic            mem_read;
    logic            mem_write;
    logic [1:0]      mem_size;
    logic            mem_unsigned;
    logic [XLEN-1:0] mem_addr;
    logic [XLEN-1:0] store_data;
    logic            set_halt;
    logic            unimpl;
  } exec_res_t;

  // One result item
  typedef struct packed {
    logic [XLEN-1:0] instr_pc;
    logic [XLEN-1:0] next_pc;
    logic            taken;
    logic            mem_read;
    logic            mem_write;
    logic [1:0]      mem_size;
    logic            mem_unsigned;
    logic [XLEN-1:0] mem_addr;
    logic [XLEN-1:0] store_data;
    logic            halted;
    logic            unimpl;
  } out_item_t;

  // Register index that maps to real storage (x0 and out-of-range read as zero)
  function automatic logic reg_ok(input logic [4:0] idx);
    reg_ok = (idx != 5'd0) && (int'(idx) < REG_COUNT);
  endfunction

endpackage

@@ sv/rvx_ram.sv @@
module rvx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, two registered read ports (read returns old data)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ sv/rvx_exec.sv @@
module rvx_exec (
  input  logic [5:0]                op,
  input  logic [rvx_pkg::XLEN-1:0]  src_a,
  input  logic [rvx_pkg::XLEN-1:0]  src_b,
  input  logic [rvx_pkg::XLEN-1:0]  imm,
  input  logic [rvx_pkg::XLEN-1:0]  pc,
  output rvx_pkg::exec_res_t        res
);
  import rvx_pkg::*;

  logic [XLEN-1:0] seq_pc;
  logic [XLEN-1:0] sum_imm;
  logic [4:0]      sh_b;
  logic [4:0]      sh_i;
  logic            lt_s;
  logic            lt_u;
  logic            lt_si;
  logic            lt_ui;
  logic            eq_ab;

  always_comb begin
    seq_pc  = pc + XLEN'(INSTR_BYTES);
    sum_imm = src_a + imm;
    sh_b    = src_b[4:0];
    sh_i    = imm[4:0];
    lt_s    = $signed(src_a) < $signed(src_b);
    lt_u    = src_a < src_b;
    lt_si   = $signed(src_a) < $signed(imm);
    lt_ui   = src_a < imm;
    eq_ab   = src_a == src_b;

    res         = '0;
    res.next_pc = seq_pc;

    unique case (op)
      OP_ADD:   begin res.wr_en = 1'b1; res.wr_data = src_a + src_b; end
      OP_AND:   begin res.wr_en = 1'b1; res.wr_data = src_a & src_b; end
      OP_OR:    begin res.wr_en = 1'b1; res.wr_data = src_a | src_b; end
      OP_XOR:   begin res.wr_en = 1'b1; res.wr_data = src_a ^ src_b; end
      OP_SUB:   begin res.wr_en = 1'b1; res.wr_data = src_a - src_b; end
      OP_SLL:   begin res.wr_en = 1'b1; res.wr_data = src_a << sh_b; end
      OP_SRL:   begin res.wr_en = 1'b1; res.wr_data = src_a >> sh_b; end
      OP_SRA:   begin
        res.wr_en   = 1'b1;
        res.wr_data = XLEN'($signed(src_a) >>> sh_b);
      end
      OP_SLT:   begin res.wr_en = 1'b1; res.wr_data = XLEN'(lt_s); end
      OP_SLTU:  begin res.wr_en = 1'b1; res.wr_data = XLEN'(lt_u); end
      OP_ADDI:  begin res.wr_en = 1'b1; res.wr_data = sum_imm; end
      OP_ANDI:  begin res.wr_en = 1'b1; res.wr_data = src_a & imm; end
      OP_ORI:   begin res.wr_en = 1'b1; res.wr_data = src_a | imm; end
      OP_XORI:  begin res.wr_en = 1'b1; res.wr_data = src_a ^ imm; end
      OP_SLLI:  begin res.wr_en = 1'b1; res.wr_data = src_a << sh_i; end
      OP_SRLI:  begin res.wr_en = 1'b1; res.wr_data = src_a >> sh_i; end
      OP_SRAI:  begin
        res.wr_en   = 1'b1;
        res.wr_data = XLEN'($signed(src_a) >>> sh_i);
      end
      OP_SLTI:  begin res.wr_en = 1'b1; res.wr_data = XLEN'(lt_si); end
      OP_SLTIU: begin res.wr_en = 1'b1; res.wr_data = XLEN'(lt_ui); end
      // Loads: request only, data comes back in a later item
      OP_LB:    begin res.mem_read = 1'b1; res.mem_size = MEM_BYTE; res.mem_addr = sum_imm; end
      OP_LBU:   begin
        res.mem_read = 1'b1; res.mem_size = MEM_BYTE; res.mem_unsigned = 1'b1;
        res.mem_addr = sum_imm;
      end
      OP_LH:    begin res.mem_read = 1'b1; res.mem_size = MEM_HALF; res.mem_addr = sum_imm; end
      OP_LHU:   begin
        res.mem_read = 1'b1; res.mem_size = MEM_HALF; res.mem_unsigned = 1'b1;
        res.mem_addr = sum_imm;
      end
      OP_LW:    begin res.mem_read = 1'b1; res.mem_size = MEM_WORD; res.mem_addr = sum_imm; end
      // Stores
      OP_SB:    begin
        res.mem_write = 1'b1; res.mem_size = MEM_BYTE; res.mem_addr = sum_imm;
        res.store_data = src_b;
      end
      OP_SH:    begin
        res.mem_write = 1'b1; res.mem_size = MEM_HALF; res.mem_addr = sum_imm;
        res.store_data = src_b;
      end
      OP_SW:    begin
        res.mem_write = 1'b1; res.mem_size = MEM_WORD; res.mem_addr = sum_imm;
        res.store_data = src_b;
      end
      // Branches go to an absolute target
      OP_BEQ:   if (eq_ab)  res.next_pc = imm;
      OP_BNE:   if (!eq_ab) res.next_pc = imm;
      OP_BGE:   if (!lt_s)  res.next_pc = imm;
      OP_BGEU:  if (!lt_u)  res.next_pc = imm;
      OP_BLT:   if (lt_s)   res.next_pc = imm;
      OP_BLTU:  if (lt_u)   res.next_pc = imm;
      OP_JAL:   begin res.wr_en = 1'b1; res.wr_data = seq_pc; res.next_pc = imm; end
      OP_JALR:  begin
        res.wr_en   = 1'b1;
        res.wr_data = seq_pc;
        res.next_pc = {sum_imm[XLEN-1:1], 1'b0};
      end
      OP_AUIPC: begin res.wr_en = 1'b1; res.wr_data = pc + (imm << UPPER_SHIFT); end
      OP_LUI:   begin res.wr_en = 1'b1; res.wr_data = imm << UPPER_SHIFT; end
      OP_HCF:   res.set_halt = 1'b1;
      default:  res.unimpl = 1'b1;
    endcase

    res.taken = res.next_pc != seq_pc;
  end

endmodule

@@ sv/rv32i_execute_core.sv @@
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    action, op, rd, rs1, rs2, imm, load_data
// out_     output     out_valid / out_ready  PCs, branch mark, memory request, status
//
// One item per cycle while out_ready holds; items pass the input then result register.
// Register file reads at input transfer, execution and all state updates happen when
// the item moves from the input register into the result register.
// Reset clears the PC, halt, load tracking and register-file valid bits (all read zero).
// A stalled result register holds the input register, which then holds in_ready low.
module rv32i_execute_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic [5:0]                 in_op,
  input  logic [4:0]                 in_rd,
  input  logic [4:0]                 in_rs1,
  input  logic [4:0]                 in_rs2,
  input  logic [rvx_pkg::XLEN-1:0]   in_imm,
  input  logic [rvx_pkg::XLEN-1:0]   in_load_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rvx_pkg::XLEN-1:0]   out_instr_pc,
  output logic [rvx_pkg::XLEN-1:0]   out_next_pc,
  output logic                       out_taken_branch,
  output logic                       out_mem_read,
  output logic                       out_mem_write,
  output logic [1:0]                 out_mem_size,
  output logic                       out_mem_unsigned,
  output logic [rvx_pkg::XLEN-1:0]   out_mem_address,
  output logic [rvx_pkg::XLEN-1:0]   out_store_data,
  output logic                       out_halted,
  output logic                       out_unimplemented
);
  import rvx_pkg::*;

  // Input register
  logic            ex_vld_r;
  logic            ex_action_r;
  logic [5:0]      ex_op_r;
  logic [4:0]      ex_rd_r;
  logic [4:0]      ex_rs1_r;
  logic [4:0]      ex_rs2_r;
  logic [XLEN-1:0] ex_imm_r;
  logic [XLEN-1:0] ex_ld_data_r;
  logic            ex_v1_r;
  logic            ex_v2_r;
  logic            ex_f1_r;
  logic            ex_f2_r;
  logic [XLEN-1:0] ex_fwd_r;

  // Architectural state
  logic [XLEN-1:0]      pc_r;
  logic                 halt_r;
  logic [4:0]           ld_dst_r;
  logic                 ld_pend_r;
  logic [REG_COUNT-1:0] rf_vld_r;

  // Result register
  logic      out_vld_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;

  logic            in_fire;
  logic            exec_fire;
  logic            exe_now;
  logic            lret;
  logic            rf_we;
  logic [4:0]      rf_widx;
  logic [XLEN-1:0] rf_wdata;
  logic [XLEN-1:0] rd_a;
  logic [XLEN-1:0] rd_b;
  logic [XLEN-1:0] src_a;
  logic [XLEN-1:0] src_b;
  exec_res_t       res;

  // Handshake
  assign in_fire   = in_valid && in_ready;
  assign exec_fire = ex_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !ex_vld_r || exec_fire;

  // Register file storage
  rvx_ram #(
    .WIDTH (XLEN),
    .DEPTH (REG_COUNT)
  ) u_rf (
    .clk     (clk),
    .we      (rf_we),
    .waddr   (rf_widx[REG_AW-1:0]),
    .wdata   (rf_wdata),
    .re      (in_fire),
    .raddr_a (in_rs1[REG_AW-1:0]),
    .raddr_b (in_rs2[REG_AW-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Operand select: zero register, same-cycle write forward, unwritten entry
  always_comb begin
    if (!reg_ok(ex_rs1_r))  src_a = '0;
    else if (ex_f1_r)       src_a = ex_fwd_r;
    else if (ex_v1_r)       src_a = rd_a;
    else                    src_a = '0;
    if (!reg_ok(ex_rs2_r))  src_b = '0;
    else if (ex_f2_r)       src_b = ex_fwd_r;
    else if (ex_v2_r)       src_b = rd_b;
    else                    src_b = '0;
  end

  rvx_exec u_exec (
    .op    (ex_op_r),
    .src_a (src_a),
    .src_b (src_b),
    .imm   (ex_imm_r),
    .pc    (pc_r),
    .res   (res)
  );

  // Register write: load return or executed instruction
  always_comb begin
    exe_now  = (ex_action_r == ACT_EXEC) && !halt_r;
    lret     = (ex_action_r == ACT_LRET) && ld_pend_r;
    rf_widx  = lret ? ld_dst_r : ex_rd_r;
    rf_wdata = lret ? ex_ld_data_r : res.wr_data;
    rf_we    = exec_fire && (lret || (exe_now && res.wr_en)) && reg_ok(rf_widx);
  end

  // Input register capture, with bypass of the write done at the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_vld_r <= 1'b0;
    end else if (in_fire) begin
      ex_vld_r <= 1'b1;
    end else if (exec_fire) begin
      ex_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_action_r  <= in_action;
      ex_op_r      <= in_op;
      ex_rd_r      <= in_rd;
      ex_rs1_r     <= in_rs1;
      ex_rs2_r     <= in_rs2;
      ex_imm_r     <= in_imm;
      ex_ld_data_r <= in_load_data;
      ex_v1_r      <= rf_vld_r[in_rs1[REG_AW-1:0]];
      ex_v2_r      <= rf_vld_r[in_rs2[REG_AW-1:0]];
      ex_f1_r      <= rf_we && (rf_widx == in_rs1);
      ex_f2_r      <= rf_we && (rf_widx == in_rs2);
      ex_fwd_r     <= rf_wdata;
    end
  end

  // Architectural state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= '0;
      halt_r    <= 1'b0;
      ld_dst_r  <= '0;
      ld_pend_r <= 1'b0;
      rf_vld_r  <= '0;
    end else if (exec_fire) begin
      if (rf_we) begin
        rf_vld_r[rf_widx[REG_AW-1:0]] <= 1'b1;
      end
      if (lret) begin
        ld_pend_r <= 1'b0;
      end
      if (exe_now) begin
        pc_r <= res.next_pc;
        if (res.set_halt) begin
          halt_r <= 1'b1;
        end
        if (res.mem_read) begin
          ld_dst_r  <= ex_rd_r;
          ld_pend_r <= 1'b1;
        end
      end
    end
  end

  // Result item
  always_comb begin
    out_item_nxt          = '0;
    out_item_nxt.instr_pc = pc_r;
    if (exe_now) begin
      out_item_nxt.next_pc      = res.next_pc;
      out_item_nxt.taken        = res.taken;
      out_item_nxt.mem_read     = res.mem_read;
      out_item_nxt.mem_write    = res.mem_write;
      out_item_nxt.mem_size     = res.mem_size;
      out_item_nxt.mem_unsigned = res.mem_unsigned;
      out_item_nxt.mem_addr     = res.mem_addr;
      out_item_nxt.store_data   = res.store_data;
      out_item_nxt.halted       = halt_r || res.set_halt;
      out_item_nxt.unimpl       = res.unimpl;
    end else begin
      out_item_nxt.next_pc = pc_r;
      out_item_nxt.halted  = halt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (exec_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_instr_pc      = out_item_r.instr_pc;
  assign out_next_pc       = out_item_r.next_pc;
  assign out_taken_branch  = out_item_r.taken;
  assign out_mem_read      = out_item_r.mem_read;
  assign out_mem_write     = out_item_r.mem_write;
  assign out_mem_size      = out_item_r.mem_size;
  assign out_mem_unsigned  = out_item_r.mem_unsigned;
  assign out_mem_address   = out_item_r.mem_addr;
  assign out_store_data    = out_item_r.store_data;
  assign out_halted        = out_item_r.halted;
  assign out_unimplemented = out_item_r.unimpl;

`ifndef SYNTHESIS
  // Load returns never move the PC
  a_lret_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && (ex_action_r == ACT_LRET) |=> pc_r == $past(pc_r))
    else $error("PC moved on a load return");

  // Halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared without reset");

  // A load return always leaves no load pending
  a_lret_clears: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && (ex_action_r == ACT_LRET) |=> !ld_pend_r)
    else $error("load still pending after load return");

  // x0 is never written
  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> rf_widx != 5'd0)
    else $error("write to x0");

  // Halted items never request memory
  a_halt_no_mem: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && halt_r |=> !out_item_r.mem_read && !out_item_r.mem_write)
    else $error("memory request while halted");
`endif

endmodule
